[rtl/etld_pkg.sv]
// Package: shared types and constants for the edge timestamp line deframer.
`timescale 1ns / 1ps
`default_nettype none
package etld_pkg;

	localparam int LEN_W = 7;
	localparam int STAMP_FIELD_BYTES = 5;
	localparam int MIN_LINE_BYTES = 7;
	localparam int TS_CNT_W = 3;

	localparam logic [7:0] CH_RISE    = 8'h2F;
	localparam logic [7:0] CH_FALL    = 8'h5C;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DEBUG   = 8'h2D;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_SHORT     = 3'd1;
	localparam status_t ST_NO_NL     = 3'd2;
	localparam status_t ST_BAD_START = 3'd3;
	localparam status_t ST_CHECKSUM  = 3'd4;

	typedef struct packed {
		logic        edge_kind;
		logic [31:0] stamp;
		status_t     status;
		logic [31:0] line_count;
	} result_t;

endpackage
`default_nettype wire

[rtl/etld_if.sv]
// Interfaces: byte input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface etld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface etld_result_if;
	logic                valid;
	logic                ready;
	logic                edge_kind;
	logic [31:0]         stamp;
	etld_pkg::status_t   status;
	logic [31:0]         line_count;

	modport source (output valid, output edge_kind, output stamp, output status,
		output line_count, input ready);
	modport sink (input valid, input edge_kind, input stamp, input status,
		input line_count, output ready);
endinterface
`default_nettype wire

[rtl/etld_core.sv]
// Line state, timestamp tracking and line check for one byte per cycle while push is high.
`timescale 1ns / 1ps
`default_nettype none
module etld_core #(
	parameter int LINE_CAPACITY = 79
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [7:0]        rx_byte,
	output logic                   produced,
	output etld_pkg::result_t      result
);

	localparam logic [etld_pkg::LEN_W-1:0] CAP = etld_pkg::LEN_W'(LINE_CAPACITY);
	localparam logic [etld_pkg::LEN_W-1:0] MIN_LEN = etld_pkg::LEN_W'(etld_pkg::MIN_LINE_BYTES);
	localparam logic [etld_pkg::TS_CNT_W-1:0] TS_LAST =
		etld_pkg::TS_CNT_W'(etld_pkg::STAMP_FIELD_BYTES);

	logic [etld_pkg::LEN_W-1:0]    len_q, len_n;
	logic [7:0]                    first_q, first_n;
	logic [7:0]                    last_q, last_n;
	logic [7:0]                    pay_q [etld_pkg::STAMP_FIELD_BYTES];
	logic [7:0]                    pay_n [etld_pkg::STAMP_FIELD_BYTES];
	logic                          ts_q, ts_n;
	logic [etld_pkg::TS_CNT_W-1:0] cnt_q, cnt_n;
	logic [31:0]                   msg_q, msg_n;
	logic                          store;
	logic                          line_end;
	logic [7:0]                    sum;

	always_comb begin
		store = len_q < CAP;
		first_n = (store && len_q == '0) ? rx_byte : first_q;
		last_n = store ? rx_byte : last_q;
		for (int i = 0; i < etld_pkg::STAMP_FIELD_BYTES; i++) begin
			pay_n[i] = (store && len_q == etld_pkg::LEN_W'(i + 1)) ? rx_byte : pay_q[i];
		end
		len_n = store ? len_q + 1'b1 : len_q;
		ts_n = ts_q;
		cnt_n = cnt_q;
		msg_n = msg_q;
		line_end = 1'b0;
		if (ts_q) begin
			cnt_n = cnt_q + 1'b1;
			if (cnt_n >= TS_LAST) begin
				ts_n = 1'b0;
			end
		end else if (rx_byte == etld_pkg::CH_RISE || rx_byte == etld_pkg::CH_FALL) begin
			ts_n = 1'b1;
			cnt_n = '0;
		end else if (rx_byte == etld_pkg::CH_NEWLINE) begin
			line_end = 1'b1;
			msg_n = msg_q + 32'd1;
		end
	end

	// checks run on the line as it stands after this byte is stored
	always_comb begin
		sum = pay_n[0] + pay_n[1] + pay_n[2] + pay_n[3];
		result.edge_kind = 1'b0;
		result.stamp = '0;
		result.line_count = msg_n;
		if (len_n < MIN_LEN) begin
			result.status = etld_pkg::ST_SHORT;
		end else if (last_n != etld_pkg::CH_NEWLINE) begin
			result.status = etld_pkg::ST_NO_NL;
		end else if (first_n != etld_pkg::CH_RISE && first_n != etld_pkg::CH_FALL) begin
			result.status = etld_pkg::ST_BAD_START;
		end else if (sum != pay_n[4]) begin
			result.status = etld_pkg::ST_CHECKSUM;
		end else begin
			result.status = etld_pkg::ST_OK;
			result.stamp = {pay_n[3], pay_n[2], pay_n[1], pay_n[0]};
			result.edge_kind = (first_n != etld_pkg::CH_RISE);
		end
		produced = push && line_end && first_n != etld_pkg::CH_DEBUG;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			first_q <= '0;
			last_q <= '0;
			ts_q <= 1'b0;
			cnt_q <= '0;
			msg_q <= '0;
		end else if (push) begin
			len_q <= line_end ? '0 : len_n;
			first_q <= first_n;
			last_q <= last_n;
			ts_q <= ts_n;
			cnt_q <= cnt_n;
			msg_q <= msg_n;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			for (int i = 0; i < etld_pkg::STAMP_FIELD_BYTES; i++) begin
				pay_q[i] <= pay_n[i];
			end
		end
	end

endmodule
`default_nettype wire

[rtl/edge_timestamp_line_deframer.sv]
// Top level: byte deframer with registered result and skid stage.
//
//  channel  dir  payload                                     handshake
//  rx       in   rx_byte[7:0]                                valid/ready
//  res      out  edge_kind, stamp[31:0], status[2:0],
//                line_count[31:0]                            valid/ready
//
// One byte per cycle while rx is ready; each byte updates the line state in the cycle it is taken.
// The newline byte that ends a line registers its result beat (none for debug lines).
// The result register plus one skid entry keep rx ready while one result waits;
// rx stalls only while both hold a beat.
// arst_n clears line state except the payload bytes, the line counter and both result valids.
`timescale 1ns / 1ps
`default_nettype none
module edge_timestamp_line_deframer #(
	parameter int LINE_CAPACITY = 79
) (
	input wire logic             clk,
	input wire logic             arst_n,
	etld_byte_if.sink            rx,
	etld_result_if.source        res
);

	logic               push;
	logic               pop;
	logic               produced;
	etld_pkg::result_t  result;
	etld_pkg::result_t  out_q;
	etld_pkg::result_t  skid_q;
	logic               out_valid_q;
	logic               skid_valid_q;

	assign rx.ready = !skid_valid_q;
	assign push = rx.valid && rx.ready;
	assign pop = out_valid_q && res.ready;

	etld_core #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.rx_byte(rx.rx_byte),
		.produced(produced),
		.result(result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (produced) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (produced) begin
			if (out_valid_q && !pop) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign res.valid = out_valid_q;
	assign res.edge_kind = out_q.edge_kind;
	assign res.stamp = out_q.stamp;
	assign res.status = out_q.status;
	assign res.line_count = out_q.line_count;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while result register is empty");

	a_skid_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && !res.ready && produced))
		else $error("skid filled without a stalled result");

	a_error_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != etld_pkg::ST_OK |-> res.stamp == '0 && !res.edge_kind)
		else $error("error beat carries a stamp or fall kind");

	a_drain_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && pop |=> out_valid_q && !skid_valid_q)
		else $error("skid beat lost on drain");

endmodule
`default_nettype wire

[bench/tb_edge_timestamp_line_deframer.sv]
// Testbench for the edge timestamp line deframer: random byte lines, line predictor, result check.
`timescale 1ns / 1ps
module tb_edge_timestamp_line_deframer;

	localparam int LINE_CAP = 79;
	localparam int PAUSE_MARK = -1;
	localparam int TARGET_BYTES = 2000;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int IDLE_PCT = 18;
	localparam int MAX_PRINTS = 40;

	logic clk = 1'b0;
	logic arst_n;

	etld_byte_if rx_if ();
	etld_result_if res_if ();

	edge_timestamp_line_deframer #(
		.LINE_CAPACITY(LINE_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if.sink),
		.res(res_if.source)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	int pending_bytes[$];
	etld_pkg::result_t expected_results[$];
	int queued_bytes = 0;
	int bytes_sent = 0;
	int errors = 0;
	int cycles = 0;
	logic quiet;

	assign quiet = (cycles >= 1500) && (cycles < 3000);

	// line state mirror
	logic [6:0]  line_len;
	logic [7:0]  first_b;
	logic [7:0]  payload [0:etld_pkg::STAMP_FIELD_BYTES-1];
	logic [7:0]  last_b;
	logic        in_ts;
	logic [2:0]  ts_cnt;
	logic [31:0] line_total;

	task automatic report_mismatch(string what, longint got, longint want);
		if (errors < MAX_PRINTS)
			$display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $time);
		errors++;
	endtask

	task automatic predict_line_byte(logic [7:0] b);
		etld_pkg::result_t r;
		logic [7:0] sum;
		if (line_len < LINE_CAP) begin
			if (line_len == 0)
				first_b = b;
			else if (line_len <= etld_pkg::STAMP_FIELD_BYTES)
				payload[line_len - 1] = b;
			last_b = b;
			line_len = line_len + 7'd1;
		end
		if (in_ts) begin
			ts_cnt = ts_cnt + 3'd1;
			if (ts_cnt >= etld_pkg::STAMP_FIELD_BYTES)
				in_ts = 1'b0;
		end else if (b == etld_pkg::CH_RISE || b == etld_pkg::CH_FALL) begin
			in_ts = 1'b1;
			ts_cnt = '0;
		end else if (b == etld_pkg::CH_NEWLINE) begin
			line_total = line_total + 32'd1;
			if (first_b != etld_pkg::CH_DEBUG) begin
				r.edge_kind = 1'b0;
				r.stamp = '0;
				r.line_count = line_total;
				sum = payload[0] + payload[1] + payload[2] + payload[3];
				if (line_len < etld_pkg::MIN_LINE_BYTES)
					r.status = etld_pkg::ST_SHORT;
				else if (last_b != etld_pkg::CH_NEWLINE)
					r.status = etld_pkg::ST_NO_NL;
				else if (first_b != etld_pkg::CH_RISE && first_b != etld_pkg::CH_FALL)
					r.status = etld_pkg::ST_BAD_START;
				else if (sum != payload[4])
					r.status = etld_pkg::ST_CHECKSUM;
				else begin
					r.status = etld_pkg::ST_OK;
					r.stamp = {payload[3], payload[2], payload[1], payload[0]};
					r.edge_kind = (first_b == etld_pkg::CH_FALL);
				end
				expected_results.push_back(r);
			end
			line_len = '0;
		end
	endtask

	task automatic add_byte(int b);
		pending_bytes.push_back(b);
		queued_bytes++;
	endtask

	function automatic logic [7:0] safe_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == etld_pkg::CH_NEWLINE || b == etld_pkg::CH_RISE || b == etld_pkg::CH_FALL);
		return b;
	endfunction

	// mostly random, sometimes a control character
	function automatic logic [7:0] content_byte();
		case ($urandom_range(15))
			0: return etld_pkg::CH_RISE;
			1: return etld_pkg::CH_FALL;
			2: return etld_pkg::CH_NEWLINE;
			3: return 8'h00;
			4: return 8'hFF;
			5: return etld_pkg::CH_DEBUG;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic add_stamp_line(logic [7:0] start, logic [31:0] val, bit good_sum, int extra);
		logic [7:0] sum;
		sum = val[7:0] + val[15:8] + val[23:16] + val[31:24];
		if (!good_sum)
			sum = sum + 8'($urandom_range(255, 1));
		add_byte(start);
		for (int i = 0; i < 4; i++)
			add_byte(val[8*i +: 8]);
		add_byte(sum);
		for (int i = 0; i < extra; i++)
			add_byte(safe_byte());
		add_byte(etld_pkg::CH_NEWLINE);
	endtask

	// driver
	always @(posedge clk) begin
		logic       nv;
		logic [7:0] nb;
		if (!arst_n) begin
			rx_if.valid <= 1'b0;
		end else begin
			if (rx_if.valid && rx_if.ready) begin
				predict_line_byte(rx_if.rx_byte);
				bytes_sent++;
			end
			nv = 1'b0;
			nb = rx_if.rx_byte;
			if (rx_if.valid && !rx_if.ready) begin
				nv = 1'b1;
			end else begin
				if (pending_bytes.size() > 0 && pending_bytes[0] == PAUSE_MARK &&
						expected_results.size() == 0)
					void'(pending_bytes.pop_front());
				if (pending_bytes.size() > 0 && pending_bytes[0] != PAUSE_MARK &&
						(quiet || $urandom_range(99) >= IDLE_PCT)) begin
					nv = 1'b1;
					nb = 8'(pending_bytes.pop_front());
				end
			end
			rx_if.valid <= nv;
			rx_if.rx_byte <= nb;
		end
	end

	// monitor
	always @(posedge clk) begin
		etld_pkg::result_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected beat, line_count", res_if.line_count, 0);
				end else begin
					want = expected_results.pop_front();
					if (res_if.edge_kind !== want.edge_kind)
						report_mismatch("edge_kind", res_if.edge_kind, want.edge_kind);
					if (res_if.stamp !== want.stamp)
						report_mismatch("stamp", res_if.stamp, want.stamp);
					if (res_if.status !== want.status)
						report_mismatch("status", res_if.status, want.status);
					if (res_if.line_count !== want.line_count)
						report_mismatch("line_count", res_if.line_count, want.line_count);
				end
			end
			res_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout: %0d beats still expected", expected_results.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int kind;
		int n;
		bit mid_pause_done;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = '0;
		res_if.ready = 1'b0;
		line_len = '0;
		first_b = '0;
		for (int i = 0; i < etld_pkg::STAMP_FIELD_BYTES; i++)
			payload[i] = '0;
		last_b = '0;
		in_ts = 1'b0;
		ts_cnt = '0;
		line_total = '0;
		mid_pause_done = 1'b0;

		// directed: good rise, good fall, short, debug, bad start
		add_stamp_line(etld_pkg::CH_RISE, 32'h0000_0000, 1'b1, 0);
		add_stamp_line(etld_pkg::CH_FALL, 32'hFFFF_FFFF, 1'b1, 0);
		add_byte("x");
		add_byte(etld_pkg::CH_NEWLINE);
		add_byte(etld_pkg::CH_DEBUG);
		add_byte(etld_pkg::CH_NEWLINE);
		add_byte("A");
		for (int i = 0; i < 5; i++)
			add_byte(safe_byte());
		add_byte(etld_pkg::CH_NEWLINE);

		while (queued_bytes < TARGET_BYTES) begin
			kind = $urandom_range(99);
			if (kind < 55) begin
				logic [31:0] val;
				val = $urandom();
				for (int i = 0; i < 4; i++)
					if ($urandom_range(7) == 0)
						val[8*i +: 8] = content_byte();
				add_stamp_line($urandom_range(1) ? etld_pkg::CH_RISE : etld_pkg::CH_FALL, val,
					$urandom_range(99) < 85, ($urandom_range(4) == 0) ? $urandom_range(5, 1) : 0);
			end else if (kind < 65) begin
				add_byte(etld_pkg::CH_DEBUG);
				n = $urandom_range(10);
				for (int i = 0; i < n; i++)
					add_byte(safe_byte());
				add_byte(etld_pkg::CH_NEWLINE);
			end else if (kind < 73) begin
				add_byte(safe_byte());
				for (int i = 0; i < 5; i++)
					add_byte(content_byte());
				add_byte(etld_pkg::CH_NEWLINE);
			end else if (kind < 82) begin
				n = $urandom_range(5);
				for (int i = 0; i < n; i++)
					add_byte(safe_byte());
				add_byte(etld_pkg::CH_NEWLINE);
			end else if (kind < 84) begin
				// overflows the line buffer
				add_stamp_line(etld_pkg::CH_RISE, $urandom(), 1'b1, $urandom_range(90, 70));
			end else begin
				n = $urandom_range(8, 1);
				for (int i = 0; i < n; i++)
					add_byte($urandom_range(255));
			end
			if ($urandom_range(99) == 0)
				pending_bytes.push_back(PAUSE_MARK);
			if (!mid_pause_done && queued_bytes >= TARGET_BYTES / 2) begin
				pending_bytes.push_back(PAUSE_MARK);
				mid_pause_done = 1'b1;
			end
		end
		add_byte(etld_pkg::CH_NEWLINE);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() > 0 || rx_if.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() > 0)
			report_mismatch("missing beats", 0, expected_results.size());

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/etld_pkg.sv
rtl/etld_if.sv
rtl/etld_core.sv
rtl/edge_timestamp_line_deframer.sv
bench/tb_edge_timestamp_line_deframer.sv
